>>> rtl/rhc_pkg.sv
// Package for the RGB to HSV converter.
// Holds the sector codes, default fraction widths and the item sideband type.
// No dependencies.
`default_nettype none

package rhc_pkg;

	// Default fraction widths of hue and saturation
	localparam int HUE_FRAC_BITS_DEF = 6;
	localparam int SAT_FRAC_BITS_DEF = 16;

	// Field widths
	localparam int CH_W  = 8;
	localparam int HUE_W = 15;
	localparam int SAT_W = 17;
	// 60 * 255 needs 14 bits
	localparam int M60_W = 14;

	// Hexcone sector of the largest channel
	localparam logic [1:0] SEC_RED   = 2'd0;
	localparam logic [1:0] SEC_GREEN = 2'd1;
	localparam logic [1:0] SEC_BLUE  = 2'd2;

	// Per-item data that travels alongside the division chain
	typedef struct packed {
		logic [CH_W-1:0] value;   // largest channel, also saturation divisor
		logic [CH_W-1:0] delta;   // max - min, also hue divisor
		logic [1:0]      sector;
		logic            neg;     // hue offset is subtracted
	} rhc_side_t;

endpackage

`default_nettype wire

>>> rtl/rhc_front.sv
// Input stage: unpacks the pixel, finds max, min, sector and forms both dividends.
// Depends on rhc_pkg.
`default_nettype none

module rhc_front #(
	parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
	parameter int SAT_FRAC_BITS = rhc_pkg::SAT_FRAC_BITS_DEF,
	parameter int NUM_W         = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic [23:0]           packed_rgb,
	output logic                       valid_s1,
	output rhc_pkg::rhc_side_t         side_s1,
	output logic [NUM_W-1:0]           hnum_s1,
	output logic [NUM_W-1:0]           snum_s1
);
	import rhc_pkg::*;

	logic [CH_W-1:0]  r, g, b;
	logic [CH_W-1:0]  mx, mn;
	logic [CH_W-1:0]  op_a, op_b, mag;
	logic [1:0]       sector;
	logic             neg;
	logic [M60_W-1:0] m60;

	assign r = packed_rgb[23:16];
	assign g = packed_rgb[15:8];
	assign b = packed_rgb[7:0];

	// Largest channel and sector; ties go to red, then green
	always_comb begin
		if (r >= g && r >= b) begin
			mx     = r;
			sector = SEC_RED;
			op_a   = g;
			op_b   = b;
		end else if (g >= b) begin
			mx     = g;
			sector = SEC_GREEN;
			op_a   = b;
			op_b   = r;
		end else begin
			mx     = b;
			sector = SEC_BLUE;
			op_a   = r;
			op_b   = g;
		end
	end

	// Smallest channel
	always_comb begin
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
	end

	// Magnitude of the hue offset, times 60
	assign neg = (op_a < op_b);
	assign mag = neg ? (op_b - op_a) : (op_a - op_b);
	assign m60 = M60_W'(mag) * M60_W'(60);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		side_s1.value  <= mx;
		side_s1.delta  <= mx - mn;
		side_s1.sector <= sector;
		side_s1.neg    <= neg;
		hnum_s1        <= {{(NUM_W-M60_W){1'b0}}, m60} << HUE_FRAC_BITS;
		snum_s1        <= {{(NUM_W-CH_W){1'b0}}, mx - mn} << SAT_FRAC_BITS;
	end

endmodule

`default_nettype wire

>>> rtl/rhc_div_cell.sv
// One cell of the division chain: a restoring step for hue and for saturation.
// Depends on rhc_pkg.
`default_nettype none

module rhc_div_cell #(
	parameter int NUM_W = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire rhc_pkg::rhc_side_t in_side,
	input  wire logic [7:0]         in_hrem,
	input  wire logic [NUM_W-1:0]   in_hnum,
	input  wire logic [NUM_W-1:0]   in_hquo,
	input  wire logic [7:0]         in_srem,
	input  wire logic [NUM_W-1:0]   in_snum,
	input  wire logic [NUM_W-1:0]   in_squo,
	output logic                    out_valid,
	output rhc_pkg::rhc_side_t      out_side,
	output logic [7:0]              out_hrem,
	output logic [NUM_W-1:0]        out_hnum,
	output logic [NUM_W-1:0]        out_hquo,
	output logic [7:0]              out_srem,
	output logic [NUM_W-1:0]        out_snum,
	output logic [NUM_W-1:0]        out_squo
);
	import rhc_pkg::*;

	logic [CH_W:0] h_t, h_d, s_t, s_d;
	logic          h_ge, s_ge;

	// Hue step: divide by delta
	assign h_t  = {in_hrem, in_hnum[NUM_W-1]};
	assign h_ge = (h_t >= {1'b0, in_side.delta});
	assign h_d  = h_t - {1'b0, in_side.delta};

	// Saturation step: divide by max
	assign s_t  = {in_srem, in_snum[NUM_W-1]};
	assign s_ge = (s_t >= {1'b0, in_side.value});
	assign s_d  = s_t - {1'b0, in_side.value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_side <= in_side;
		out_hrem <= h_ge ? h_d[CH_W-1:0] : h_t[CH_W-1:0];
		out_hnum <= in_hnum << 1;
		out_hquo <= {in_hquo[NUM_W-2:0], h_ge};
		out_srem <= s_ge ? s_d[CH_W-1:0] : s_t[CH_W-1:0];
		out_snum <= in_snum << 1;
		out_squo <= {in_squo[NUM_W-2:0], s_ge};
	end

endmodule

`default_nettype wire

>>> rtl/rhc_back.sv
// Output stage: places the hue quotient in its sector and registers the result.
// Depends on rhc_pkg.
`default_nettype none

module rhc_back #(
	parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
	parameter int NUM_W         = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire rhc_pkg::rhc_side_t in_side,
	input  wire logic [7:0]         in_hrem,
	input  wire logic [NUM_W-1:0]   in_hquo,
	input  wire logic [NUM_W-1:0]   in_squo,
	output logic                    done,
	output logic [14:0]             hue_fixed,
	output logic [16:0]             saturation_fixed,
	output logic [7:0]              value_level
);
	import rhc_pkg::*;

	// Wide enough for 360 degrees and for the output field
	localparam int HW = (10 + HUE_FRAC_BITS > HUE_W) ? 10 + HUE_FRAC_BITS : HUE_W;
	localparam logic [HW-1:0] U120 = HW'(120 << HUE_FRAC_BITS);
	localparam logic [HW-1:0] U240 = HW'(240 << HUE_FRAC_BITS);
	localparam logic [HW-1:0] U360 = HW'(360 << HUE_FRAC_BITS);

	logic [HW-1:0] qh, base, hue;
	logic [HW-1:0] rnd;

	assign qh  = in_hquo[HW-1:0];
	// A non-zero remainder on a negative offset floors one step further down
	assign rnd = HW'(|in_hrem);

	always_comb begin
		case (in_side.sector)
			SEC_RED:   base = in_side.neg ? U360 : '0;
			SEC_GREEN: base = U120;
			SEC_BLUE:  base = U240;
			default:   base = '0;
		endcase
	end

	// Grey pixel gives hue zero
	always_comb begin
		if (in_side.delta == '0) begin
			hue = '0;
		end else if (in_side.neg) begin
			hue = base - qh - rnd;
		end else begin
			hue = base + qh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		hue_fixed        <= hue[HUE_W-1:0];
		// Black pixel gives saturation zero; the quotient may be narrower than the field
		saturation_fixed <= (in_side.value == '0) ? '0 : SAT_W'(in_squo);
		value_level      <= in_side.value;
	end

endmodule

`default_nettype wire

>>> rtl/rgb_to_hsv_converter.sv
// Top level of the RGB to HSV converter (hexcone, fixed point).
// Depends on rhc_pkg, rhc_front, rhc_div_cell and rhc_back.
//
// One pixel is taken in every clock cycle; busy is always low. Each item
// passes the input register, the row of NUM_W division cells and the output
// register before it comes out on done, where NUM_W is the larger of
// 14 + HUE_FRAC_BITS and 8 + SAT_FRAC_BITS. Each division cell resolves
// one quotient bit of both the hue and the saturation per cycle. Results
// show for exactly one cycle and the receiver cannot stall them, so it must
// take every result as it appears.
`default_nettype none

module rgb_to_hsv_converter #(
	parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
	parameter int SAT_FRAC_BITS = rhc_pkg::SAT_FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [23:0] packed_rgb,
	output logic             done,
	output logic [14:0]      hue_fixed,
	output logic [16:0]      saturation_fixed,
	output logic [7:0]       value_level
);
	import rhc_pkg::*;

	localparam int HNW   = M60_W + HUE_FRAC_BITS;
	localparam int SNW   = CH_W + SAT_FRAC_BITS;
	localparam int NUM_W = (HNW > SNW) ? HNW : SNW;

	// Chain taps, one per cell boundary
	logic              valid_c [0:NUM_W];
	rhc_side_t         side_c  [0:NUM_W];
	logic [CH_W-1:0]   hrem_c  [0:NUM_W];
	logic [NUM_W-1:0]  hnum_c  [0:NUM_W];
	logic [NUM_W-1:0]  hquo_c  [0:NUM_W];
	logic [CH_W-1:0]   srem_c  [0:NUM_W];
	logic [NUM_W-1:0]  snum_c  [0:NUM_W];
	logic [NUM_W-1:0]  squo_c  [0:NUM_W];

	assign busy = 1'b0;

	rhc_front #(
		.HUE_FRAC_BITS (HUE_FRAC_BITS),
		.SAT_FRAC_BITS (SAT_FRAC_BITS),
		.NUM_W         (NUM_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start),
		.packed_rgb (packed_rgb),
		.valid_s1   (valid_c[0]),
		.side_s1    (side_c[0]),
		.hnum_s1    (hnum_c[0]),
		.snum_s1    (snum_c[0])
	);

	// Remainders and quotients start empty
	assign hrem_c[0] = '0;
	assign hquo_c[0] = '0;
	assign srem_c[0] = '0;
	assign squo_c[0] = '0;

	// Row of division cells, one quotient bit each
	for (genvar i = 0; i < NUM_W; i++) begin : g_cell
		rhc_div_cell #(
			.NUM_W (NUM_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_side   (side_c[i]),
			.in_hrem   (hrem_c[i]),
			.in_hnum   (hnum_c[i]),
			.in_hquo   (hquo_c[i]),
			.in_srem   (srem_c[i]),
			.in_snum   (snum_c[i]),
			.in_squo   (squo_c[i]),
			.out_valid (valid_c[i+1]),
			.out_side  (side_c[i+1]),
			.out_hrem  (hrem_c[i+1]),
			.out_hnum  (hnum_c[i+1]),
			.out_hquo  (hquo_c[i+1]),
			.out_srem  (srem_c[i+1]),
			.out_snum  (snum_c[i+1]),
			.out_squo  (squo_c[i+1])
		);
	end

	rhc_back #(
		.HUE_FRAC_BITS (HUE_FRAC_BITS),
		.NUM_W         (NUM_W)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (valid_c[NUM_W]),
		.in_side          (side_c[NUM_W]),
		.in_hrem          (hrem_c[NUM_W]),
		.in_hquo          (hquo_c[NUM_W]),
		.in_squo          (squo_c[NUM_W]),
		.done             (done),
		.hue_fixed        (hue_fixed),
		.saturation_fixed (saturation_fixed),
		.value_level      (value_level)
	);

	// Final remainder of saturation and spent dividends are not needed
	logic unused_tail;
	assign unused_tail = ^{srem_c[NUM_W], hnum_c[NUM_W], snum_c[NUM_W]};

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for rgb_to_hsv_converter: drives packed RGB pixels,
// predicts hue, saturation and value per item and checks each strobed result.
// Depends on rhc_pkg and rgb_to_hsv_converter.

module tb_top;
	import rhc_pkg::*;

	// One HSV result at the output widths of the block
	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [SAT_W-1:0] sat;
		logic [CH_W-1:0]  val;
	} hsv_t;

	// Pixel sent and the HSV it should turn into
	typedef struct {
		logic [23:0] px;
		hsv_t        hsv;
	} pending_hsv_t;

	// Expected HSV per accepted pixel, oldest first
	class hsv_ledger;
		pending_hsv_t awaited_hsv[$];
		int           mismatches;

		static function longint floor_quot(longint num, longint den);
			if (num >= 0)
				return num / den;
			return -((-num + den - 1) / den);
		endfunction

		// Hexcone conversion, exact integer maths then floored
		static function hsv_t convert_pixel(logic [23:0] px);
			longint r, g, b, mx, mn, delta, unit, hue, sat;
			hsv_t   res;
			r = longint'(px[23:16]);
			g = longint'(px[15:8]);
			b = longint'(px[7:0]);
			mx = r;
			mn = r;
			if (g > mx) mx = g;
			if (b > mx) mx = b;
			if (g < mn) mn = g;
			if (b < mn) mn = b;
			delta = mx - mn;
			unit = longint'(1) << HUE_FRAC_BITS_DEF;
			hue = 0;
			sat = 0;
			if (mx != 0)
				sat = (delta << SAT_FRAC_BITS_DEF) / mx;
			// ties go to red, then green
			if (delta != 0) begin
				if (mx == r) begin
					hue = floor_quot(60 * unit * (g - b), delta);
					// red sector wraps below zero
					if (hue < 0)
						hue += 360 * unit;
				end else if (mx == g) begin
					hue = 120 * unit + floor_quot(60 * unit * (b - r), delta);
				end else begin
					hue = 240 * unit + floor_quot(60 * unit * (r - g), delta);
				end
			end
			res.hue = hue[HUE_W-1:0];
			res.sat = sat[SAT_W-1:0];
			res.val = mx[CH_W-1:0];
			return res;
		endfunction

		function void note_pixel(logic [23:0] px);
			pending_hsv_t e;
			e.px = px;
			e.hsv = convert_pixel(px);
			awaited_hsv.push_back(e);
		endfunction

		function void check_hsv(hsv_t got);
			pending_hsv_t e;
			if (awaited_hsv.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no item outstanding: hue %0d sat %0d val %0d",
						$time, got.hue, got.sat, got.val);
				return;
			end
			e = awaited_hsv.pop_front();
			if (got.hue !== e.hsv.hue || got.sat !== e.hsv.sat || got.val !== e.hsv.val) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: pixel %06h: expected hue %0d sat %0d val %0d",
						$time, e.px, e.hsv.hue, e.hsv.sat, e.hsv.val);
					$display("%0t: pixel %06h: got hue %0d sat %0d val %0d",
						$time, e.px, got.hue, got.sat, got.val);
				end
			end
		endfunction

		function int outstanding();
			return awaited_hsv.size();
		endfunction
	endclass

	// Extremes, ties, grey, black and the red-sector wrap
	localparam logic [23:0] EDGE_PIXELS [0:23] = '{
		24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000, 24'h00FF00,
		24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hFF00FE,
		24'hFF8000, 24'h80FF00, 24'h00FF80, 24'h0080FF, 24'h8000FF, 24'h010000,
		24'h000100, 24'h000001, 24'hFEFFFF, 24'h7F7F80, 24'hAAAAAA, 24'h5555AA
	};
	localparam int ITEMS_PER_PHASE = 325;
	localparam int DRAIN_CYCLES    = 40;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [23:0] packed_rgb = '0;
	logic        busy;
	logic        done;
	logic [14:0] hue_fixed;
	logic [16:0] saturation_fixed;
	logic [7:0]  value_level;

	hsv_ledger ledger = new;

	rgb_to_hsv_converter dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.packed_rgb       (packed_rgb),
		.done             (done),
		.hue_fixed        (hue_fixed),
		.saturation_fixed (saturation_fixed),
		.value_level      (value_level)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Results are taken on every strobe
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			ledger.check_hsv('{hue: hue_fixed, sat: saturation_fixed, val: value_level});
	end

	// Offer one item and hold it until it is taken
	task automatic send_pixel(logic [23:0] px);
		start <= 1'b1;
		packed_rgb <= px;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		ledger.note_pixel(px);
	endtask

	// Random idle cycles before the next item
	task automatic sender_gap(int pct);
		while ($urandom_range(99) < pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Hold off until every outstanding item has come back
	task automatic wait_drained();
		int guard;
		guard = 0;
		start <= 1'b0;
		while (ledger.outstanding() != 0 && guard < 2000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	// Mostly arbitrary pixels, with grey, tied and near-black ones mixed in
	function automatic logic [23:0] random_pixel();
		int          pick;
		logic [7:0]  c, d;
		logic [23:0] px;
		pick = $urandom_range(99);
		c = 8'($urandom_range(255));
		d = 8'($urandom_range(255));
		if (pick < 55) begin
			px = 24'($urandom());
		end else if (pick < 70) begin
			px = {c, c, c};
		end else if (pick < 85) begin
			case ($urandom_range(2))
				0: px = {c, c, d};
				1: px = {d, c, c};
				default: px = {c, d, c};
			endcase
		end else begin
			px = {8'($urandom_range(3)), 8'($urandom_range(3)), 8'($urandom_range(3))};
		end
		return px;
	endfunction

	// Stimulus: reset, directed pixels, then four random phases
	initial begin
		int idle_pct [4];
		idle_pct = '{0, 83, 0, 16};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(EDGE_PIXELS); i++)
			send_pixel(EDGE_PIXELS[i]);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				sender_gap(idle_pct[ph]);
				send_pixel(random_pixel());
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (ledger.outstanding() != 0)
			$display("%0d items never produced a result", ledger.outstanding());
		if (ledger.mismatches == 0 && ledger.outstanding() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Hard stop well past the slowest correct run
	initial begin
		#5000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
